[src/homogeneous_point_transform_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the homogeneous point transform
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define HPT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define HPT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HPT_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define HPT_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

[src/hpt_pkg.sv]
// ---------------------------------------------------------------------------
// hpt_pkg
// Types and constants shared by the point transform modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hpt_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int COORD_FRAC  = COORD_WIDTH / 2;
    localparam int COEF_W      = 16;
    localparam int NUM_ROWS    = 4;
    localparam int ROW_W       = NUM_ROWS * COEF_W;
    localparam int PROD_W      = COEF_W + COORD_WIDTH;
    localparam int ACC_W       = PROD_W + 2;
    localparam int CFG_IDX_W   = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] IDX_ROW_ZERO  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_ROW_ONE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_ROW_TWO   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_ROW_THREE = 8'd3;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] in_x;
        logic signed [COORD_WIDTH-1:0] in_y;
        logic signed [COORD_WIDTH-1:0] in_z;
        logic                          in_last;
    } point_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
        logic                          overflow_flag;
        logic                          zero_w_flag;
        logic                          out_last;
    } result_t;

    // per-item flags riding along the divider
    typedef struct packed {
        logic last;
        logic wzero;
        logic qneg;
        logic nzero;
        logic pre_ovf;
    } side_t;

    typedef logic [NUM_ROWS-1:0][ROW_W-1:0] matrix_t;

endpackage

`default_nettype wire

[src/homogeneous_point_transform.sv]
// ---------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 homogeneous transform of Q16.16 points with divide by w.
// ---------------------------------------------------------------------------
// One point is taken in every cycle; busy is always low. Each result comes
// out on result with done high for one cycle, after the products, the row
// sums, a register that forms magnitudes, one divider stage per quotient bit
// and an output register. The receiver cannot stall; results must be taken
// as they appear. The user must write matrix rows through the cfg port only
// while no point is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

`include "homogeneous_point_transform_assert.svh"

module homogeneous_point_transform
#(
    parameter int COEF_FRAC_BITS = 12
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire hpt_pkg::point_t                    point,
    output logic                                    done,
    output hpt_pkg::result_t                        result,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [hpt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [hpt_pkg::ROW_W-1:0]          cfg_data
);

    localparam int CW  = hpt_pkg::COORD_WIDTH;
    localparam int F   = hpt_pkg::COORD_FRAC;
    localparam int AW  = hpt_pkg::ACC_W;
    localparam int NR  = hpt_pkg::NUM_ROWS;
    localparam int KW  = hpt_pkg::COEF_W;
    localparam int LAT = CW + 4;
    localparam logic [CW-1:0] SIGN_BIT = {1'b1, {(CW-1){1'b0}}};

    hpt_pkg::matrix_t matrix_reg;
    logic accept;
    logic mac_valid;
    logic mac_last;
    logic signed [AW-1:0] acc [NR];

    // prep stage
    logic [AW-1:0]   rem_reg  [3];
    logic [CW-1:0]   lo_reg   [3];
    logic [AW-1:0]   wmag_reg;
    hpt_pkg::side_t  side_reg [3];
    logic            prep_valid_reg;
    logic [AW-1:0]   wmag;
    logic            wneg;
    logic            wzero;

    // divider outputs
    logic            dv_valid [3];
    logic [CW-1:0]   dv_q     [3];
    hpt_pkg::side_t  dv_side  [3];

    // output stage
    hpt_pkg::result_t result_reg;
    hpt_pkg::result_t result_next;
    logic             done_reg;
    logic [CW-1:0]    coord [3];
    logic [2:0]       ovf;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // matrix registers, identity at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NR; r++)
                matrix_reg[r] <= hpt_pkg::ROW_W'(1) << (KW*r + COEF_FRAC_BITS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hpt_pkg::IDX_ROW_ZERO:  matrix_reg[0] <= cfg_data;
                hpt_pkg::IDX_ROW_ONE:   matrix_reg[1] <= cfg_data;
                hpt_pkg::IDX_ROW_TWO:   matrix_reg[2] <= cfg_data;
                hpt_pkg::IDX_ROW_THREE: matrix_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    hpt_mac u_mac
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .point     (point),
        .matrix    (matrix_reg),
        .out_valid (mac_valid),
        .out_last  (mac_last),
        .acc       (acc)
    );

    // magnitudes, signs and the early overflow test (quotient >= 2^CW)
    assign wneg  = acc[3][AW-1];
    assign wmag  = wneg ? AW'(-acc[3]) : AW'(acc[3]);
    assign wzero = (acc[3] == '0);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic          nneg;
            logic [AW-1:0] nmag;
            nneg = acc[i][AW-1];
            nmag = nneg ? AW'(-acc[i]) : AW'(acc[i]);
            rem_reg[i]          <= AW'(nmag >> (CW - F));
            lo_reg[i]           <= {nmag[CW-F-1:0], {F{1'b0}}};
            side_reg[i].last    <= mac_last;
            side_reg[i].wzero   <= wzero;
            side_reg[i].qneg    <= nneg != wneg;
            side_reg[i].nzero   <= (nmag == '0);
            side_reg[i].pre_ovf <= {{F{1'b0}}, nmag} >= {wmag, {F{1'b0}}};
        end
        wmag_reg <= wmag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_valid_reg <= 1'b0;
        else
            prep_valid_reg <= mac_valid;
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            hpt_div #(.AW(AW), .QW(CW)) u_div
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (prep_valid_reg),
                .in_rem    (rem_reg[g]),
                .in_lo     (lo_reg[g]),
                .in_div    (wmag_reg),
                .in_side   (side_reg[g]),
                .out_valid (dv_valid[g]),
                .out_q     (dv_q[g]),
                .out_side  (dv_side[g])
            );
        end
    endgenerate

    // saturation, sign and zero-w handling
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [CW-1:0] lim;
            logic [CW-1:0] mag;
            lim    = dv_side[i].qneg ? SIGN_BIT : SIGN_BIT - 1'b1;
            ovf[i] = !dv_side[i].wzero && (dv_side[i].pre_ovf || dv_q[i] > lim);
            mag    = ovf[i] ? lim : dv_q[i];
            if (dv_side[i].wzero)
                coord[i] = dv_side[i].nzero ? '0 : lim;
            else
                coord[i] = dv_side[i].qneg ? -mag : mag;
        end
        result_next.out_x         = coord[0];
        result_next.out_y         = coord[1];
        result_next.out_z         = coord[2];
        result_next.overflow_flag = |ovf;
        result_next.zero_w_flag   = dv_side[0].wzero;
        result_next.out_last      = dv_side[0].last;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid[0];
    end

    assign done   = done_reg;
    assign result = result_reg;

    logic accept_live;
    logic lanes_agree;
    logic x_at_bound;
    assign accept_live = accept && rst_n;
    assign lanes_agree = dv_valid[0] == dv_valid[1] && dv_valid[0] == dv_valid[2];
    assign x_at_bound  = result.out_x == '0 || result.out_x == SIGN_BIT
                         || result.out_x == SIGN_BIT - 1'b1;

    `HPT_ASSERT_IMP(a_lanes_in_step, clk, rst_n, 1'b1, lanes_agree)
    `HPT_ASSERT_IMP(a_zero_w_no_ovf, clk, rst_n, done && result.zero_w_flag, !result.overflow_flag)
    `HPT_ASSERT_IMP(a_zero_w_x_bound, clk, rst_n, done && result.zero_w_flag, x_at_bound)
    `HPT_ASSERT_IMP(a_latency, clk, rst_n, $past(accept_live, LAT), done)

endmodule

`default_nettype wire

[src/hpt_mac.sv]
// ---------------------------------------------------------------------------
// hpt_mac
// Two-stage matrix multiply: registered products, then registered row sums.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hpt_mac
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire hpt_pkg::point_t                     point,
    input  wire hpt_pkg::matrix_t                    matrix,
    output logic                                     out_valid,
    output logic                                     out_last,
    output logic signed [hpt_pkg::ACC_W-1:0]         acc [hpt_pkg::NUM_ROWS]
);

    localparam int PW = hpt_pkg::PROD_W;
    localparam int AW = hpt_pkg::ACC_W;
    localparam int CW = hpt_pkg::COORD_WIDTH;
    localparam int NR = hpt_pkg::NUM_ROWS;
    localparam int KW = hpt_pkg::COEF_W;

    logic signed [PW-1:0] prod_reg  [NR][NR];
    logic signed [PW-1:0] prod_next [NR][NR];
    logic signed [CW-1:0] crd [3];
    logic signed [AW-1:0] acc_reg  [NR];
    logic signed [AW-1:0] acc_next [NR];
    logic [1:0] valid_reg;
    logic [1:0] last_reg;

    assign crd[0] = point.in_x;
    assign crd[1] = point.in_y;
    assign crd[2] = point.in_z;

    // products; the fourth column multiplies 1.0 and is a shift
    always_comb
    begin
        for (int r = 0; r < NR; r++)
        begin
            for (int c = 0; c < 3; c++)
                prod_next[r][c] = PW'($signed(matrix[r][KW*c +: KW])) * PW'(crd[c]);
            prod_next[r][3] = PW'($signed(matrix[r][KW*3 +: KW])) <<< hpt_pkg::COORD_FRAC;
        end
    end

    // row sums
    always_comb
    begin
        for (int r = 0; r < NR; r++)
            acc_next[r] = AW'(prod_reg[r][0]) + AW'(prod_reg[r][1])
                        + AW'(prod_reg[r][2]) + AW'(prod_reg[r][3]);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        last_reg <= {last_reg[0], point.in_last};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[0], in_valid};
    end

    assign out_valid = valid_reg[1];
    assign out_last  = last_reg[1];
    assign acc       = acc_reg;

endmodule

`default_nettype wire

[src/hpt_div.sv]
// ---------------------------------------------------------------------------
// hpt_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hpt_div
#(
    parameter int AW = 50,
    parameter int QW = 32
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [AW-1:0]   in_rem,
    input  wire logic [QW-1:0]   in_lo,
    input  wire logic [AW-1:0]   in_div,
    input  wire hpt_pkg::side_t  in_side,
    output logic                 out_valid,
    output logic [QW-1:0]        out_q,
    output hpt_pkg::side_t       out_side
);

    logic [AW-1:0]   rem_reg  [QW];
    logic [QW-1:0]   lo_reg   [QW];
    logic [QW-1:0]   q_reg    [QW];
    logic [AW-1:0]   div_reg  [QW];
    hpt_pkg::side_t  side_reg [QW];
    logic [QW-1:0]   valid_reg;

    genvar j;
    generate
        for (j = 0; j < QW; j++)
        begin : g_stage
            logic [AW-1:0]  rem_s;
            logic [QW-1:0]  lo_s;
            logic [QW-1:0]  q_s;
            logic [AW-1:0]  div_s;
            hpt_pkg::side_t side_s;
            logic           val_s;
            logic [AW:0]    trial;
            logic [AW:0]    diff;
            logic           ge;

            if (j == 0)
            begin : g_first
                assign rem_s  = in_rem;
                assign lo_s   = in_lo;
                assign q_s    = '0;
                assign div_s  = in_div;
                assign side_s = in_side;
                assign val_s  = in_valid;
            end
            else
            begin : g_next
                assign rem_s  = rem_reg[j-1];
                assign lo_s   = lo_reg[j-1];
                assign q_s    = q_reg[j-1];
                assign div_s  = div_reg[j-1];
                assign side_s = side_reg[j-1];
                assign val_s  = valid_reg[j-1];
            end

            // shift in one dividend bit, subtract if it fits
            assign trial = {rem_s, lo_s[QW-1]};
            assign diff  = trial - {1'b0, div_s};
            assign ge    = trial >= {1'b0, div_s};

            always_ff @(posedge clk)
            begin
                rem_reg[j]  <= ge ? diff[AW-1:0] : trial[AW-1:0];
                lo_reg[j]   <= lo_s << 1;
                q_reg[j]    <= {q_s[QW-2:0], ge};
                div_reg[j]  <= div_s;
                side_reg[j] <= side_s;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[j] <= 1'b0;
                else
                    valid_reg[j] <= val_s;
            end
        end
    endgenerate

    assign out_valid = valid_reg[QW-1];
    assign out_q     = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

`default_nettype wire

[verif/tb_homogeneous_point_transform.sv]
// ---------------------------------------------------------------------------
// tb_homogeneous_point_transform
// Self-checking bench for the 4x4 homogeneous point transform. Points are
// driven through the start/busy port under several matrix settings. A
// scoreboard predicts each transformed point with exact wide arithmetic and
// checks every done strobe against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// Predicts transformed points and checks results in order
class point_scoreboard;
    hpt_pkg::matrix_t   rows;
    hpt_pkg::result_t   pending[$];
    int                 mismatches;
    int                 checked;

    function void reset_rows();
        rows[0] = 64'h0000_0000_0000_1000;
        rows[1] = 64'h0000_0000_1000_0000;
        rows[2] = 64'h0000_1000_0000_0000;
        rows[3] = 64'h1000_0000_0000_0000;
        mismatches = 0;
        checked = 0;
    endfunction

    function void write_row(logic [hpt_pkg::CFG_IDX_W-1:0] idx,
                            logic [hpt_pkg::ROW_W-1:0] data);
        // indexes past row three are dropped by the block
        if (idx <= hpt_pkg::IDX_ROW_THREE)
            rows[idx[1:0]] = data;
    endfunction

    function hpt_pkg::result_t transform(hpt_pkg::point_t p);
        logic signed [63:0]  coord [4];
        logic signed [63:0]  acc [4];
        logic signed [15:0]  coef;
        logic [127:0]        wmag;
        logic [127:0]        nmag;
        logic [127:0]        quo;
        logic [127:0]        lim;
        logic [31:0]         res [3];
        logic                wneg;
        logic                nneg;
        logic                qneg;
        logic                ovf;
        hpt_pkg::result_t    r;
        coord[0] = 64'(p.in_x);
        coord[1] = 64'(p.in_y);
        coord[2] = 64'(p.in_z);
        coord[3] = 64'sd65536;
        // exact row sums over (x, y, z, 1.0)
        for (int i = 0; i < 4; i++)
        begin
            acc[i] = 0;
            for (int k = 0; k < 4; k++)
            begin
                coef = rows[i][16*k +: 16];
                acc[i] = acc[i] + coef * coord[k];
            end
        end
        wneg = acc[3][63];
        wmag = wneg ? 128'(-acc[3]) : 128'(acc[3]);
        ovf = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            nneg = acc[i][63];
            nmag = nneg ? 128'(-acc[i]) : 128'(acc[i]);
            if (wmag == 0)
            begin
                // zero w: sign of numerator picks the bound
                if (nmag == 0)
                    res[i] = 32'h0;
                else
                    res[i] = nneg ? 32'h8000_0000 : 32'h7fff_ffff;
            end
            else
            begin
                qneg = nneg ^ wneg;
                lim = qneg ? 128'h8000_0000 : 128'h7fff_ffff;
                quo = (nmag << hpt_pkg::COORD_FRAC) / wmag;
                if (quo > lim)
                begin
                    ovf = 1'b1;
                    quo = lim;
                end
                res[i] = qneg ? 32'(-quo) : quo[31:0];
            end
        end
        r.out_x = res[0];
        r.out_y = res[1];
        r.out_z = res[2];
        r.overflow_flag = ovf;
        r.zero_w_flag = (wmag == 0);
        r.out_last = p.in_last;
        return r;
    endfunction

    function void note_point(hpt_pkg::point_t p);
        pending.push_back(transform(p));
    endfunction

    function void check_result(hpt_pkg::result_t act);
        hpt_pkg::result_t want;
        checked++;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result %h", act);
            return;
        end
        want = pending.pop_front();
        if (act.out_x !== want.out_x || act.out_y !== want.out_y ||
            act.out_z !== want.out_z || act.overflow_flag !== want.overflow_flag ||
            act.zero_w_flag !== want.zero_w_flag || act.out_last !== want.out_last)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: point result mismatch: exp x=%h y=%h z=%h ov=%b zw=%b l=%b",
                         want.out_x, want.out_y, want.out_z, want.overflow_flag,
                         want.zero_w_flag, want.out_last,
                         " act x=%h y=%h z=%h ov=%b zw=%b l=%b",
                         act.out_x, act.out_y, act.out_z, act.overflow_flag,
                         act.zero_w_flag, act.out_last);
        end
    endfunction
endclass

module tb_homogeneous_point_transform;
    localparam int LATENCY     = 36;
    localparam int CYCLE_LIMIT = 200000;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    hpt_pkg::point_t                    point;
    logic                               done;
    hpt_pkg::result_t                   result;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [hpt_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [hpt_pkg::ROW_W-1:0]          cfg_data;

    point_scoreboard        sb;
    int                     cycles;
    int                     items_sent;
    int                     cfg_writes;
    bit                     idle_on;

    homogeneous_point_transform u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point     (point),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // result monitor; old values sampled at the edge
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    // send one point, holding start until accepted
    task automatic send_point(hpt_pkg::point_t p);
        int gap;
        if (idle_on && $urandom_range(99) < 19)
        begin
            start <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        point <= p;
        do @(posedge clk); while (busy);
        sb.note_point(p);
        items_sent++;
    endtask

    // hold off until every predicted result has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // valid stays high across back to back writes; the caller drops it
    task automatic write_cfg(logic [hpt_pkg::CFG_IDX_W-1:0] idx,
                             logic [hpt_pkg::ROW_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_row(idx, data);
        cfg_writes++;
    endtask

    task automatic load_matrix(logic [hpt_pkg::ROW_W-1:0] r0, logic [hpt_pkg::ROW_W-1:0] r1,
                               logic [hpt_pkg::ROW_W-1:0] r2, logic [hpt_pkg::ROW_W-1:0] r3);
        drain();
        write_cfg(hpt_pkg::IDX_ROW_ZERO, r0);
        write_cfg(hpt_pkg::IDX_ROW_ONE, r1);
        write_cfg(hpt_pkg::IDX_ROW_TWO, r2);
        write_cfg(hpt_pkg::IDX_ROW_THREE, r3);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: rand_coord = $urandom;
            1: rand_coord = 32'($signed($urandom_range(2000000)) - 1000000);
            2: rand_coord = 32'($signed($urandom_range(131072)) - 65536);
            default: rand_coord = ($urandom_range(1)) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [63:0] rand_row();
        rand_row = {$urandom, $urandom};
    endfunction

    task automatic random_points(int n);
        hpt_pkg::point_t p;
        for (int i = 0; i < n; i++)
        begin
            p.in_x = rand_coord();
            p.in_y = rand_coord();
            p.in_z = rand_coord();
            p.in_last = $urandom_range(1);
            send_point(p);
        end
    endtask

    initial
    begin
        hpt_pkg::point_t p;
        logic [31:0] edge_vals [6];
        sb = new();
        sb.reset_rows();
        cycles = 0;
        items_sent = 0;
        cfg_writes = 0;
        idle_on = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        point = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: coordinate extremes under the reset identity
        edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                      32'h1, 32'h0001_0000};
        for (int i = 0; i < 6; i++)
        begin
            p.in_x = edge_vals[i];
            p.in_y = edge_vals[(i + 1) % 6];
            p.in_z = edge_vals[(i + 2) % 6];
            p.in_last = i[0];
            send_point(p);
        end

        // zero w: numerators positive, negative and zero
        load_matrix(64'h0000_0000_0000_1000, 64'h0000_0000_f000_0000,
                    64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000);
        p = '{32'h0001_0000, 32'h0002_0000, 32'h0, 1'b1};
        send_point(p);
        p = '{32'hffff_0000, 32'hfffe_0000, 32'h1234, 1'b0};
        send_point(p);
        p = '{32'h0, 32'h0, 32'h0, 1'b1};
        send_point(p);

        // out of range quotients with tiny w, and negative w
        load_matrix(64'h0000_0000_0000_7fff, 64'h0000_0000_8000_0000,
                    64'h0000_7fff_0000_0000, 64'h0001_0000_0000_0000);
        p = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0};
        send_point(p);
        p = '{32'h0000_0001, 32'h8000_0000, 32'h0000_0100, 1'b1};
        send_point(p);
        load_matrix(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                    64'h0000_1000_0000_0000, 64'hf000_0000_0000_0000);
        p = '{32'h0003_0000, 32'hfffd_0000, 32'h0, 1'b0};
        send_point(p);

        // ignored index must leave rows alone
        drain();
        write_cfg(8'd4, 64'h0);
        write_cfg(8'hff, 64'h0);
        cfg_valid <= 1'b0;
        p = '{32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 1'b1};
        send_point(p);

        // random phases over several matrices
        load_matrix(64'h1000_1000_1000_1000, 64'h0, 64'h0, 64'h1000_0000_0000_0000);
        random_points(70);
        idle_on = 1'b0;
        load_matrix(64'h8000_8000_8000_8000, 64'h7fff_7fff_7fff_7fff,
                    64'h8000_7fff_8000_7fff, 64'h7fff_8000_7fff_8000);
        random_points(80);
        idle_on = 1'b1;
        for (int ph = 0; ph < 5; ph++)
        begin
            load_matrix(rand_row(), rand_row(), rand_row(),
                        {16'h1000 + 16'($urandom_range(255)), 16'($urandom_range(31)),
                         16'($urandom_range(31)), 16'($urandom_range(31))});
            random_points(70);
        end
        load_matrix(rand_row(), rand_row(), rand_row(), rand_row());
        random_points(80);
        load_matrix(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                    64'h0000_1000_0000_0000, 64'h1000_0000_0000_0000);
        random_points(40);

        drain();
        $display("Sent %0d points across %0d register writes; %0d results checked",
                 items_sent, cfg_writes, sb.checked);
        $display("Matrices covered identity, zero w, tiny and negative w, extremes, random");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.pending.size());
            $display("Verification failed");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+src
src/hpt_pkg.sv
src/hpt_mac.sv
src/hpt_div.sv
src/homogeneous_point_transform.sv
verif/tb_homogeneous_point_transform.sv
